/* hw/rtl/heartbeat_interval_qualifier_macros.svh */
// ----------------------------------------------------------------------------
// Heartbeat interval qualifier assertion macros
// Shared property forms for the qualifier's internal checks.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_INTERVAL_QUALIFIER_MACROS_SVH
`define HEARTBEAT_INTERVAL_QUALIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HIQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HIQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/hiq_pkg.sv */
// ----------------------------------------------------------------------------
// Heartbeat interval qualifier package
// Widths, constants and shared types of the qualifier.
// ----------------------------------------------------------------------------
package hiq_pkg;

  localparam int TicksW     = 24;
  localparam int RateW      = 16;
  localparam int CountW     = 8;
  localparam int TpsW       = 16;
  localparam int ReadIdxW   = 3;
  localparam int StoreDepth = 8;
  localparam int StoreIdxW  = 3;

  // ticks_per_second * 60 fits in 22 bits
  localparam int DividendW  = 22;
  localparam int DivCountW  = $clog2(DividendW + 1);

  localparam int PaddrW     = 5;
  localparam int PdataW     = 32;

  typedef enum logic [2:0] {
    REG_RUN_LENGTH       = 3'd0,
    REG_FASTEST_INTERVAL = 3'd1,
    REG_SLOWEST_INTERVAL = 3'd2,
    REG_TICKS_PER_SECOND = 3'd3,
    REG_MAX_VARIANCE     = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* hw/rtl/heartbeat_interval_qualifier.sv */
// ----------------------------------------------------------------------------
// Heartbeat interval qualifier
// Qualifies pulse sensor scans, converts the beat interval to a rate and
// keeps accepted rates in a ring store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one scan or read item with
//   action, sensor_high, timer_ticks and read_index. Output channel
//   (out_valid / out_stall) returns exactly one result item per input item.
//   The user must write registers over APB only while the block is idle; the block does not enforce this.
// Item flow:
//   Read items, low scans and high scans that do not yield a rate finish at
//   the accept edge: the result is registered there. A qualified run whose
//   interval lies inside the window is accepted, then passes the restoring
//   divider (one quotient bit per cycle), the quotient handover and the
//   variance band check and store, which waits while the output stalls.
//   in_stall stays high during that time.
// Reset:
//   rst is synchronous; it clears the run counter, previous rate, the ring
//   store and its pointer, and loads the register defaults.
// Stall:
//   A waiting result holds in the output register; a new item is taken only
//   when that register is empty or is drained in the same cycle.
// ----------------------------------------------------------------------------
`include "heartbeat_interval_qualifier_macros.svh"

module heartbeat_interval_qualifier (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hiq_pkg::PaddrW-1:0]    paddr,
  input  logic [hiq_pkg::PdataW-1:0]    pwdata,
  output logic [hiq_pkg::PdataW-1:0]    prdata,
  output logic                          pready,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic                          sensor_high,
  input  logic [hiq_pkg::TicksW-1:0]    timer_ticks,
  input  logic [hiq_pkg::ReadIdxW-1:0]  read_index,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          rate_ready,
  output logic [hiq_pkg::RateW-1:0]     rate,
  output logic                          rate_accepted,
  output logic [hiq_pkg::StoreIdxW-1:0] write_position,
  output logic                          restart_timer,
  output logic                          stop_scan,
  output logic [hiq_pkg::RateW-1:0]     read_value
);
  import hiq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [CountW-1:0] run_length;
  logic [TicksW-1:0] fastest_interval;
  logic [TicksW-1:0] slowest_interval;
  logic [TpsW-1:0]   ticks_per_second;
  logic [CountW-1:0] max_variance;

  // block state
  logic [CountW-1:0] run_count;
  logic [CountW-1:0] previous_rate;

  logic              cfg_wr;
  reg_index_t        cfg_idx;

  logic              in_acc;
  logic              out_free;
  logic [CountW-1:0] run_count_next;
  logic              run_done;
  logic              in_window;
  logic              div_start;

  logic [DividendW-1:0] dividend;
  logic [DividendW-1:0] quotient;
  div_status_t          div_st;

  logic [RateW-1:0]     rate_sat;
  logic signed [17:0]   rate_s;
  logic signed [17:0]   band_lo;
  logic signed [17:0]   band_hi;
  logic                 band_ok;

  logic                 store_wr;
  logic [RateW-1:0]     store_rd;
  logic [StoreIdxW-1:0] wr_ptr_next;

  logic                 finish_load;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_index_t'(paddr[PaddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length       <= CountW'(5);
      fastest_interval <= TicksW'(8192);
      slowest_interval <= TicksW'(65536);
      ticks_per_second <= TpsW'(32768);
      max_variance     <= CountW'(20);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RUN_LENGTH:       run_length       <= pwdata[CountW-1:0];
        REG_FASTEST_INTERVAL: fastest_interval <= pwdata[TicksW-1:0];
        REG_SLOWEST_INTERVAL: slowest_interval <= pwdata[TicksW-1:0];
        REG_TICKS_PER_SECOND: ticks_per_second <= pwdata[TpsW-1:0];
        REG_MAX_VARIANCE:     max_variance     <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RUN_LENGTH:       prdata = PdataW'(run_length);
      REG_FASTEST_INTERVAL: prdata = PdataW'(fastest_interval);
      REG_SLOWEST_INTERVAL: prdata = PdataW'(slowest_interval);
      REG_TICKS_PER_SECOND: prdata = PdataW'(ticks_per_second);
      REG_MAX_VARIANCE:     prdata = PdataW'(max_variance);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Item intake and run tracking
  // ---------------------------------------------------------------------------
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;

  assign run_count_next = run_count + 1'b1;
  assign run_done       = (run_count_next == run_length);
  assign in_window      = (timer_ticks > fastest_interval) &&
                          (timer_ticks < slowest_interval);
  assign div_start      = in_acc && !action && sensor_high && run_done && in_window;

  // ticks_per_second * 60 as 64x - 4x
  assign dividend = {ticks_per_second, 6'b0} - {4'b0, ticks_per_second, 2'b0};

  hiq_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (timer_ticks),
    .quotient (quotient),
    .status   (div_st)
  );

  // ---------------------------------------------------------------------------
  // Saturation and variance band
  // ---------------------------------------------------------------------------
  always_comb begin
    rate_sat = (|quotient[DividendW-1:RateW]) ? {RateW{1'b1}} : quotient[RateW-1:0];
    rate_s   = $signed({2'b0, rate_sat});
    band_lo  = $signed({10'b0, previous_rate}) - $signed({10'b0, max_variance});
    band_hi  = $signed({10'b0, previous_rate}) + $signed({10'b0, max_variance});
    band_ok  = (rate_s < band_hi) && (rate_s > band_lo);
  end

  assign finish_load = (state == ST_FINISH) && out_free;
  assign store_wr    = finish_load && band_ok;

  hiq_store u_store (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (store_wr),
    .wr_data     (rate_sat),
    .rd_index    (read_index),
    .rd_data     (store_rd),
    .wr_ptr_next (wr_ptr_next)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      run_count     <= '0;
      previous_rate <= '0;
      out_valid     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            rate_ready     <= 1'b0;
            rate           <= '0;
            rate_accepted  <= 1'b0;
            write_position <= wr_ptr_next;
            restart_timer  <= !action && sensor_high && run_done;
            stop_scan      <= !action && !sensor_high;
            read_value     <= action ? store_rd : '0;
            // hold the result until the rate is known
            out_valid      <= !div_start;
            if (!action) begin
              run_count <= sensor_high ? run_count_next : '0;
            end
            if (div_start) begin
              state <= ST_DIV;
            end
          end else if (!out_stall) begin
            out_valid <= 1'b0;
          end
        end
        ST_DIV: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
          end
          if (div_st.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            rate_ready     <= 1'b1;
            rate           <= rate_sat;
            rate_accepted  <= band_ok;
            write_position <= wr_ptr_next;
            previous_rate  <= rate_sat[CountW-1:0];
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `HIQ_ASSERT_SAME(a_div_done_in_div, clk, rst, div_st.done, state == ST_DIV,
                   "divider finished outside ST_DIV")
  `HIQ_ASSERT_SAME(a_div_busy_in_div, clk, rst, div_st.busy, state == ST_DIV,
                   "divider busy outside ST_DIV")
  `HIQ_ASSERT_NEXT(a_low_scan_clears, clk, rst, in_acc && !action && !sensor_high,
                   run_count == '0 && out_valid && stop_scan,
                   "low scan did not clear the run")
  `HIQ_ASSERT_SAME(a_accepted_has_rate, clk, rst, out_valid && rate_accepted,
                   rate_ready && restart_timer, "stored rate without a computed rate")
  `HIQ_ASSERT_NEXT(a_store_write_result, clk, rst, store_wr, out_valid && rate_accepted,
                   "store write without an accepted result")

endmodule

/* hw/rtl/hiq_divider.sv */
// ----------------------------------------------------------------------------
// Heartbeat interval qualifier divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hiq_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [hiq_pkg::DividendW-1:0]  dividend,
  input  logic [hiq_pkg::TicksW-1:0]     divisor,
  output logic [hiq_pkg::DividendW-1:0]  quotient,
  output hiq_pkg::div_status_t           status
);
  import hiq_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DivCountW-1:0] count;
  logic [TicksW-1:0]    rem;
  logic [DividendW-1:0] num;
  logic [TicksW-1:0]    dvs;

  logic [TicksW:0]      rem_sh;
  logic [TicksW:0]      sub;
  logic                 ge;
  logic [TicksW-1:0]    rem_next;
  logic [DividendW-1:0] num_next;
  logic                 last_step;

  always_comb begin
    rem_sh   = {rem, num[DividendW-1]};
    sub      = rem_sh - {1'b0, dvs};
    ge       = (rem_sh >= {1'b0, dvs});
    rem_next = ge ? sub[TicksW-1:0] : rem_sh[TicksW-1:0];
    num_next = {num[DividendW-2:0], ge};
  end

  assign last_step = (count == DivCountW'(DividendW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && last_step;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        num   <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= rem_next;
        num   <= num_next;
        count <= count + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient    = num;
  assign status.busy = busy;
  assign status.done = done;

endmodule

/* hw/rtl/hiq_store.sv */
// ----------------------------------------------------------------------------
// Heartbeat interval qualifier rate store
// Ring of accepted rates with its write pointer.
// ----------------------------------------------------------------------------
module hiq_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [hiq_pkg::RateW-1:0]     wr_data,
  input  logic [hiq_pkg::ReadIdxW-1:0]  rd_index,
  output logic [hiq_pkg::RateW-1:0]     rd_data,
  output logic [hiq_pkg::StoreIdxW-1:0] wr_ptr_next
);
  import hiq_pkg::*;

  logic [RateW-1:0]     entries [StoreDepth];
  logic [StoreIdxW-1:0] wr_ptr;

  always_comb begin
    wr_ptr_next = wr_ptr;
    if (wr_en) begin
      // wrap at the store depth
      if (wr_ptr == StoreIdxW'(StoreDepth - 1)) begin
        wr_ptr_next = '0;
      end else begin
        wr_ptr_next = wr_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      for (int i = 0; i < StoreDepth; i++) begin
        entries[i] <= '0;
      end
    end else begin
      wr_ptr <= wr_ptr_next;
      if (wr_en) begin
        entries[wr_ptr] <= wr_data;
      end
    end
  end

  always_comb begin
    if ({1'b0, rd_index} < (ReadIdxW + 1)'(StoreDepth)) begin
      rd_data = entries[rd_index[StoreIdxW-1:0]];
    end else begin
      rd_data = '0;
    end
  end

endmodule

/* tb/sv/heartbeat_interval_qualifier_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat interval qualifier testbench
// Drives scan and read items through the valid/stall channels, predicts each
// result from a local model of the run counter, rate window, variance band
// and ring store, and compares every result field by field. The run steps
// through several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module heartbeat_interval_qualifier_test;
  import hiq_pkg::*;

  localparam int PhaseItems = 200;
  localparam int IdleLimit  = 2000;

  typedef enum logic {ACT_SCAN = 1'b0, ACT_READ = 1'b1} action_t;

  typedef struct packed {
    action_t                act;
    logic                   level;
    logic [TicksW-1:0]      ticks;
    logic [ReadIdxW-1:0]    ridx;
  } scan_item_t;

  typedef struct packed {
    logic                   ready;
    logic [RateW-1:0]       rate;
    logic                   accepted;
    logic [StoreIdxW-1:0]   wpos;
    logic                   restart;
    logic                   stop;
    logic [RateW-1:0]       rval;
  } beat_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PaddrW-1:0]      paddr = '0;
  logic [PdataW-1:0]      pwdata = '0;
  logic [PdataW-1:0]      prdata;
  logic                   pready;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   action = 1'b0;
  logic                   sensor_high = 1'b0;
  logic [TicksW-1:0]      timer_ticks = '0;
  logic [ReadIdxW-1:0]    read_index = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   rate_ready;
  logic [RateW-1:0]       rate;
  logic                   rate_accepted;
  logic [StoreIdxW-1:0]   write_position;
  logic                   restart_timer;
  logic                   stop_scan;
  logic [RateW-1:0]       read_value;

  heartbeat_interval_qualifier u_dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .action, .sensor_high, .timer_ticks, .read_index,
    .out_valid, .out_stall, .rate_ready, .rate, .rate_accepted,
    .write_position, .restart_timer, .stop_scan, .read_value
  );

  // register copies
  logic [CountW-1:0]      cfg_run_len;
  logic [TicksW-1:0]      cfg_fast;
  logic [TicksW-1:0]      cfg_slow;
  logic [TpsW-1:0]        cfg_tps;
  logic [7:0]             cfg_band;

  // qualifier state
  logic [CountW-1:0]      run_cnt;
  logic [7:0]             last_rate;
  logic [RateW-1:0]       rate_ring [StoreDepth];
  logic [StoreIdxW-1:0]   ring_pos;

  scan_item_t             scan_items [$];
  beat_result_t           expected_beats [$];
  int                     items_total = 0;
  int                     items_accepted = 0;
  int                     results_seen = 0;
  int                     errors = 0;
  int                     idle_pct = 0;
  int                     stall_pct = 0;
  int                     idle_cycles = 0;
  logic                   in_taken = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_error($sformatf("result %0d: %s = %0d, expected %0d", results_seen, name,
                             got, want));
    end
  endtask

  function automatic beat_result_t predict_beat(scan_item_t it);
    beat_result_t r;
    int unsigned quot;
    int lo;
    int hi;
    r = '0;
    if (it.act == ACT_READ) begin
      r.rval = rate_ring[it.ridx];
    end else if (it.level) begin
      run_cnt = run_cnt + 8'd1;
      if (run_cnt == cfg_run_len) begin
        r.restart = 1'b1;
        // zero ticks never passes the window, so the divide is safe
        if (it.ticks > cfg_fast && it.ticks < cfg_slow) begin
          quot = (32'(cfg_tps) * 32'd60) / 32'(it.ticks);
          r.rate = (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
          r.ready = 1'b1;
          lo = int'(last_rate) - int'(cfg_band);
          hi = int'(last_rate) + int'(cfg_band);
          if (int'(r.rate) < hi && int'(r.rate) > lo) begin
            r.accepted = 1'b1;
            rate_ring[ring_pos] = r.rate;
            ring_pos = ring_pos + 3'd1;
          end
          last_rate = r.rate[7:0];
        end
      end
    end else begin
      run_cnt = '0;
      r.stop = 1'b1;
    end
    r.wpos = ring_pos;
    return r;
  endfunction

  // monitor: check results, then predict for the item taken at this edge
  always @(posedge clk) begin
    beat_result_t got;
    beat_result_t want;
    scan_item_t item;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got = '{rate_ready, rate, rate_accepted, write_position, restart_timer,
                stop_scan, read_value};
        if (expected_beats.size() == 0) begin
          report_error($sformatf("unexpected result: %p", got));
        end else begin
          want = expected_beats.pop_front();
          check_field("rate_ready", got.ready, want.ready);
          check_field("rate", got.rate, want.rate);
          check_field("rate_accepted", got.accepted, want.accepted);
          check_field("write_position", got.wpos, want.wpos);
          check_field("restart_timer", got.restart, want.restart);
          check_field("stop_scan", got.stop, want.stop);
          check_field("read_value", got.rval, want.rval);
          results_seen++;
        end
      end
      if (in_taken) begin
        item = '{action_t'(action), sensor_high, timer_ticks, read_index};
        expected_beats.push_back(predict_beat(item));
        items_accepted++;
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("heartbeat_interval_qualifier verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // driver: hold a stalled item, otherwise advance or go idle
  always @(negedge clk) begin
    scan_item_t item;
    if (!rst) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!in_valid || in_taken) begin
        if (scan_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          item = scan_items.pop_front();
          action      <= item.act;
          sensor_high <= item.level;
          timer_ticks <= item.ticks;
          read_index  <= item.ridx;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_item(action_t act, logic level, logic [TicksW-1:0] ticks,
                           logic [ReadIdxW-1:0] ridx);
    scan_items.push_back('{act, level, ticks, ridx});
    items_total++;
  endtask

  task automatic push_noise();
    push_item(action_t'($urandom_range(1)), 1'($urandom_range(1)),
              TicksW'($urandom), ReadIdxW'($urandom));
  endtask

  // one well-formed run: clear, then enough high scans to qualify, the last
  // one carrying a count that aims at a rate near base_rate
  task automatic push_run(int base_rate, int spread);
    int len;
    int goal;
    longint unsigned t;
    len = (cfg_run_len == 0) ? 256 : int'(cfg_run_len);
    push_item(ACT_SCAN, 1'b0, TicksW'($urandom), ReadIdxW'($urandom));
    for (int k = 1; k < len; k++) begin
      push_item(ACT_SCAN, 1'b1, TicksW'($urandom), ReadIdxW'($urandom));
    end
    goal = base_rate + $urandom_range(2 * spread) - spread;
    if (goal < 1) goal = 1;
    t = (longint'(cfg_tps) * 60) / goal;
    if (t > 64'hFFFFFF) t = 64'hFFFFFF;
    if ($urandom_range(7) == 0) t = $urandom & 32'hFFFFFF;
    push_item(ACT_SCAN, 1'b1, TicksW'(t), ReadIdxW'($urandom));
  endtask

  task automatic apb_write(reg_index_t idx, logic [PdataW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PaddrW'(int'(idx) * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(int rl, int fast, int slow, int tps, int band);
    apb_write(REG_RUN_LENGTH, PdataW'(rl));
    apb_write(REG_FASTEST_INTERVAL, PdataW'(fast));
    apb_write(REG_SLOWEST_INTERVAL, PdataW'(slow));
    apb_write(REG_TICKS_PER_SECOND, PdataW'(tps));
    apb_write(REG_MAX_VARIANCE, PdataW'(band));
    cfg_run_len = CountW'(rl);
    cfg_fast    = TicksW'(fast);
    cfg_slow    = TicksW'(slow);
    cfg_tps     = TpsW'(tps);
    cfg_band    = 8'(band);
  endtask

  task automatic wait_drained();
    while (items_accepted != items_total || expected_beats.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic fill_phase(int base_rate, int spread);
    int phase_end;
    int pick;
    phase_end = items_total + PhaseItems;
    while (items_total < phase_end) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        push_run(base_rate, spread);
        // drift the rate so later runs test both sides of the band
        base_rate = base_rate + $urandom_range(10) - 5;
        if (base_rate < 1) base_rate = 1;
        if (base_rate > 250) base_rate = 250;
      end else if (pick < 85) begin
        push_item(ACT_READ, 1'($urandom_range(1)), TicksW'($urandom), ReadIdxW'($urandom));
      end else begin
        push_noise();
      end
    end
  endtask

  initial begin
    int fast;
    cfg_run_len = 8'd5;
    cfg_fast    = 24'd8192;
    cfg_slow    = 24'd65536;
    cfg_tps     = 16'd32768;
    cfg_band    = 8'd20;
    run_cnt     = '0;
    last_rate   = '0;
    ring_pos    = '0;
    for (int i = 0; i < StoreDepth; i++) rate_ring[i] = '0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      case (phase)
        0: begin
          // reset settings: empty store, band reaching below zero, window edges
          push_item(ACT_READ, 1'b0, 24'd0, 3'd0);
          push_item(ACT_SCAN, 1'b0, 24'hFFFFFF, 3'd7);
          repeat (4) push_item(ACT_SCAN, 1'b1, 24'd100, 3'd0);
          push_item(ACT_SCAN, 1'b1, 24'd16384, 3'd0);
          push_item(ACT_SCAN, 1'b1, 24'd0, 3'd0);
          push_item(ACT_SCAN, 1'b0, 24'd0, 3'd0);
          repeat (4) push_item(ACT_SCAN, 1'b1, 24'd200, 3'd0);
          push_item(ACT_SCAN, 1'b1, 24'd16000, 3'd0);
          push_item(ACT_READ, 1'b0, 24'd0, 3'd0);
          push_item(ACT_SCAN, 1'b0, 24'd0, 3'd0);
          repeat (4) push_item(ACT_SCAN, 1'b1, 24'd300, 3'd0);
          push_item(ACT_SCAN, 1'b1, 24'd65536, 3'd0);
          push_item(ACT_READ, 1'b1, 24'hFFFFFF, 3'd7);
          fill_phase(110, 15);
        end
        1: begin
          apply_config(1, 0, 24'hFFFFFF, 65535, 255);
          // zero count, saturated rate, then a stored rate above 255
          push_item(ACT_SCAN, 1'b0, 24'd0, 3'd0);
          push_item(ACT_SCAN, 1'b1, 24'd0, 3'd0);
          push_item(ACT_SCAN, 1'b0, 24'd0, 3'd0);
          push_item(ACT_SCAN, 1'b1, 24'd1, 3'd0);
          push_item(ACT_SCAN, 1'b0, 24'd0, 3'd0);
          push_item(ACT_SCAN, 1'b1, 24'd60000, 3'd0);
          push_item(ACT_SCAN, 1'b0, 24'd0, 3'd0);
          push_item(ACT_SCAN, 1'b1, 24'd13107, 3'd0);
          push_item(ACT_READ, 1'b0, 24'd0, 3'd1);
          fill_phase(150, 120);
        end
        2: begin
          apply_config(3, 1000, 200000, 1, 0);
          fill_phase(100, 10);
        end
        3: begin
          apply_config(255, 100, 1000000, 32768, 30);
          fill_phase(90, 20);
        end
        4: begin
          apply_config(0, 5000, 100000, 40000, 60);
          fill_phase(60, 40);
        end
        5: begin
          apply_config(2, 24'hFFFFFF, 0, 65535, 128);
          fill_phase(80, 10);
        end
        default: begin
          fast = $urandom_range(20000);
          apply_config($urandom_range(1, 12), fast, fast + $urandom_range(1000, 200000),
                       $urandom_range(1, 65535), $urandom_range(255));
          fill_phase($urandom_range(20, 230), $urandom_range(1, 40));
        end
      endcase
      wait_drained();
    end

    repeat (30) @(negedge clk);
    if (expected_beats.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_beats.size()));
    end
    if (errors == 0) begin
      $display("heartbeat_interval_qualifier verification clean");
    end else begin
      $display("heartbeat_interval_qualifier verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/hiq_pkg.sv
hw/rtl/hiq_divider.sv
hw/rtl/hiq_store.sv
hw/rtl/heartbeat_interval_qualifier.sv
tb/sv/heartbeat_interval_qualifier_test.sv
